// ===== hw/rtl/wgsp_pkg.sv =====
package wgsp_pkg;

   // Event codes on the result channel
   localparam logic [2:0] EV_HEADER = 3'd0;
   localparam logic [2:0] EV_POINT  = 3'd1;
   localparam logic [2:0] EV_START  = 3'd2;
   localparam logic [2:0] EV_DONE   = 3'd3;
   localparam logic [2:0] EV_ERROR  = 3'd4;

   // Error codes
   localparam logic [2:0] ERR_NONE   = 3'd0;
   localparam logic [2:0] ERR_TRUNC  = 3'd1;
   localparam logic [2:0] ERR_ORDER  = 3'd2;
   localparam logic [2:0] ERR_TYPE   = 3'd3;
   localparam logic [2:0] ERR_MEMBER = 3'd4;

   // Nesting levels of start events
   localparam logic [1:0] LVL_TOP    = 2'd0;
   localparam logic [1:0] LVL_MEMBER = 2'd1;
   localparam logic [1:0] LVL_RING   = 2'd2;

   // WKB geometry type codes
   localparam logic [2:0] GEOM_NONE       = 3'd0;
   localparam logic [2:0] GEOM_POINT      = 3'd1;
   localparam logic [2:0] GEOM_LINESTRING = 3'd2;
   localparam logic [2:0] GEOM_POLYGON    = 3'd3;
   localparam logic [2:0] GEOM_MPOINT     = 3'd4;
   localparam logic [2:0] GEOM_MLINE      = 3'd5;
   localparam logic [2:0] GEOM_MPOLYGON   = 3'd6;

   // Byte-order marks
   localparam logic [7:0] ORDER_LITTLE = 8'h01;
   localparam logic [7:0] ORDER_BIG    = 8'h00;

   localparam logic [31:0] GEO_SRID_RESET = 32'd4326;

   // One result item
   typedef struct packed {
      logic [2:0]  event_res;
      logic [31:0] srid;
      logic [2:0]  geom_type;
      logic [63:0] x_bits;
      logic [63:0] y_bits;
      logic [31:0] element_count;
      logic [1:0]  nest_level;
      logic [2:0]  error_code;
      logic        is_last;
   } rsp_item_type;

   // Results produced by one byte, first item first
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } rsp_pair_type;

endpackage

// ===== hw/rtl/wgsp_if.sv =====
interface wgsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wgsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_res;
   logic [31:0] srid;
   logic [2:0]  geom_type;
   logic [63:0] x_bits;
   logic [63:0] y_bits;
   logic [31:0] element_count;
   logic [1:0]  nest_level;
   logic [2:0]  error_code;
   logic        is_last;

   modport source (output valid, output event_res, output srid, output geom_type,
                   output x_bits, output y_bits, output element_count, output nest_level,
                   output error_code, output is_last, input ready);
   modport sink (input valid, input event_res, input srid, input geom_type,
                 input x_bits, input y_bits, input element_count, input nest_level,
                 input error_code, input is_last, output ready);
endinterface

// ===== hw/rtl/wgsp_parser.sv =====
module wgsp_parser
   import wgsp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  logic [7:0]   data_byte,
   input  logic         last_byte,
   input  logic [31:0]  geographic_srid,
   output rsp_pair_type results
);

   // Parse phases
   localparam logic [3:0] PH_SRID     = 4'd0;
   localparam logic [3:0] PH_ORDER    = 4'd1;
   localparam logic [3:0] PH_TYPE     = 4'd2;
   localparam logic [3:0] PH_TOPCOUNT = 4'd3;
   localparam logic [3:0] PH_MORDER   = 4'd4;
   localparam logic [3:0] PH_MTYPE    = 4'd5;
   localparam logic [3:0] PH_MCOUNT   = 4'd6;
   localparam logic [3:0] PH_RCOUNT   = 4'd7;
   localparam logic [3:0] PH_X        = 4'd8;
   localparam logic [3:0] PH_Y        = 4'd9;

   logic [3:0]  phase_ff, phase_in;
   logic [2:0]  byte_ff, byte_in;
   logic [63:0] assembly_ff, assembly_in;
   logic [63:0] first_ff, first_in;
   logic        little_ff, little_in;
   logic [31:0] srid_ff, srid_in;
   logic [2:0]  top_ff, top_in;
   logic [31:0] members_ff, members_in;
   logic [31:0] rings_ff, rings_in;
   logic [31:0] points_ff, points_in;
   logic        finished_ff, finished_in;

   logic        take_en;
   logic        long_field;
   logic        field_done;
   logic [63:0] word;
   logic [31:0] count_word;
   logic [2:0]  expect_member;

   logic        pri_valid;
   logic [2:0]  pri_event;
   logic [63:0] pri_x, pri_y;
   logic [31:0] pri_count;
   logic [1:0]  pri_level;
   logic        term_valid;
   logic [2:0]  term_event;
   logic [2:0]  term_err;
   logic        do_end_point, do_end_ring, do_end_member;
   rsp_item_type pri_item, term_item;

   // Field assembly: little-endian bytes land by position, big-endian shift in
   always_comb begin
      take_en    = (phase_ff != PH_ORDER) && (phase_ff != PH_MORDER) && (phase_ff <= PH_Y);
      long_field = (phase_ff == PH_X) || (phase_ff == PH_Y);
      field_done = long_field ? (byte_ff == 3'd7) : (byte_ff == 3'd3);
      if ((phase_ff == PH_SRID) || little_ff) begin
         word = assembly_ff | ({56'd0, data_byte} << {byte_ff, 3'b000});
      end else begin
         word = {assembly_ff[55:0], data_byte};
      end
      count_word    = word[31:0];
      expect_member = top_ff - 3'd3;
   end

   // Next parse state and the events of this byte
   always_comb begin
      phase_in    = phase_ff;
      byte_in     = byte_ff;
      assembly_in = assembly_ff;
      first_in    = first_ff;
      little_in   = little_ff;
      srid_in     = srid_ff;
      top_in      = top_ff;
      members_in  = members_ff;
      rings_in    = rings_ff;
      points_in   = points_ff;
      finished_in = finished_ff;

      pri_valid  = 1'b0;
      pri_event  = EV_HEADER;
      pri_x      = 64'd0;
      pri_y      = 64'd0;
      pri_count  = 32'd0;
      pri_level  = LVL_TOP;
      term_valid = 1'b0;
      term_event = EV_DONE;
      term_err   = ERR_NONE;
      do_end_point  = 1'b0;
      do_end_ring   = 1'b0;
      do_end_member = 1'b0;

      if (!finished_ff) begin
         if (take_en) begin
            if (field_done) begin
               assembly_in = 64'd0;
               byte_in     = 3'd0;
            end else begin
               assembly_in = word;
               byte_in     = byte_ff + 3'd1;
            end
         end

         case (phase_ff)
            PH_SRID: begin
               if (field_done) begin
                  srid_in  = count_word;
                  phase_in = PH_ORDER;
               end
            end
            PH_ORDER, PH_MORDER: begin
               if ((data_byte == ORDER_LITTLE) || (data_byte == ORDER_BIG)) begin
                  little_in = (data_byte == ORDER_LITTLE);
                  phase_in  = (phase_ff == PH_ORDER) ? PH_TYPE : PH_MTYPE;
               end else begin
                  term_valid  = 1'b1;
                  term_event  = EV_ERROR;
                  term_err    = ERR_ORDER;
                  finished_in = 1'b1;
               end
            end
            PH_TYPE: begin
               if (field_done) begin
                  if ((count_word[31:3] == 29'd0) && (count_word[2:0] != GEOM_NONE) &&
                      (count_word[2:0] != 3'd7)) begin
                     top_in    = count_word[2:0];
                     pri_valid = 1'b1;
                     pri_event = EV_HEADER;
                     phase_in  = (count_word[2:0] == GEOM_POINT) ? PH_X : PH_TOPCOUNT;
                  end else begin
                     term_valid  = 1'b1;
                     term_event  = EV_ERROR;
                     term_err    = ERR_TYPE;
                     finished_in = 1'b1;
                  end
               end
            end
            PH_TOPCOUNT: begin
               if (field_done) begin
                  pri_valid = 1'b1;
                  pri_event = EV_START;
                  pri_count = count_word;
                  pri_level = LVL_TOP;
                  if (top_ff == GEOM_LINESTRING) begin
                     points_in = count_word;
                     phase_in  = PH_X;
                  end else if (top_ff == GEOM_POLYGON) begin
                     rings_in = count_word;
                     phase_in = PH_RCOUNT;
                  end else begin
                     members_in = count_word;
                     phase_in   = PH_MORDER;
                  end
                  if (count_word == 32'd0) begin
                     term_valid  = 1'b1;
                     finished_in = 1'b1;
                  end
               end
            end
            PH_MTYPE: begin
               if (field_done) begin
                  if (count_word != {29'd0, expect_member}) begin
                     term_valid  = 1'b1;
                     term_event  = EV_ERROR;
                     term_err    = ERR_MEMBER;
                     finished_in = 1'b1;
                  end else begin
                     phase_in = (top_ff == GEOM_MPOINT) ? PH_X : PH_MCOUNT;
                  end
               end
            end
            PH_MCOUNT: begin
               if (field_done) begin
                  pri_valid = 1'b1;
                  pri_event = EV_START;
                  pri_count = count_word;
                  pri_level = LVL_MEMBER;
                  if (top_ff == GEOM_MLINE) begin
                     points_in = count_word;
                     phase_in  = PH_X;
                  end else begin
                     rings_in = count_word;
                     phase_in = PH_RCOUNT;
                  end
                  do_end_member = (count_word == 32'd0);
               end
            end
            PH_RCOUNT: begin
               if (field_done) begin
                  pri_valid = 1'b1;
                  pri_event = EV_START;
                  pri_count = count_word;
                  pri_level = LVL_RING;
                  points_in = count_word;
                  phase_in  = PH_X;
                  do_end_ring = (count_word == 32'd0);
               end
            end
            PH_X: begin
               if (field_done) begin
                  first_in = word;
                  phase_in = PH_Y;
               end
            end
            PH_Y: begin
               if (field_done) begin
                  pri_valid = 1'b1;
                  pri_event = EV_POINT;
                  if (srid_ff == geographic_srid) begin
                     pri_x = word;
                     pri_y = first_ff;
                  end else begin
                     pri_x = first_ff;
                     pri_y = word;
                  end
                  do_end_point = 1'b1;
               end
            end
            default: begin
               phase_in = PH_SRID;
            end
         endcase

         // Unwind the nesting after a point or an empty count
         if (do_end_point) begin
            if (top_ff == GEOM_POINT) begin
               term_valid  = 1'b1;
               finished_in = 1'b1;
            end else if (top_ff == GEOM_MPOINT) begin
               do_end_member = 1'b1;
            end else begin
               points_in = points_ff - 32'd1;
               if (points_in != 32'd0) begin
                  phase_in = PH_X;
               end else if (top_ff == GEOM_LINESTRING) begin
                  term_valid  = 1'b1;
                  finished_in = 1'b1;
               end else if (top_ff == GEOM_MLINE) begin
                  do_end_member = 1'b1;
               end else begin
                  do_end_ring = 1'b1;
               end
            end
         end
         if (do_end_ring) begin
            rings_in = rings_ff - 32'd1;
            if (rings_in != 32'd0) begin
               phase_in = PH_RCOUNT;
            end else if (top_ff == GEOM_POLYGON) begin
               term_valid  = 1'b1;
               finished_in = 1'b1;
            end else begin
               do_end_member = 1'b1;
            end
         end
         if (do_end_member) begin
            members_in = members_ff - 32'd1;
            if (members_in != 32'd0) begin
               phase_in = PH_MORDER;
            end else begin
               term_valid  = 1'b1;
               finished_in = 1'b1;
            end
         end

         // Frame ended with the geometry still open
         if (!finished_in && last_byte) begin
            term_valid  = 1'b1;
            term_event  = EV_ERROR;
            term_err    = ERR_TRUNC;
            finished_in = 1'b1;
         end
      end
   end

   // Pack the events; terminal event follows the primary one
   always_comb begin
      pri_item.event_res     = pri_event;
      pri_item.srid          = srid_in;
      pri_item.geom_type     = top_in;
      pri_item.x_bits        = pri_x;
      pri_item.y_bits        = pri_y;
      pri_item.element_count = pri_count;
      pri_item.nest_level    = pri_level;
      pri_item.error_code    = ERR_NONE;
      pri_item.is_last       = !term_valid;

      term_item.event_res     = term_event;
      term_item.srid          = srid_in;
      term_item.geom_type     = top_in;
      term_item.x_bits        = 64'd0;
      term_item.y_bits        = 64'd0;
      term_item.element_count = 32'd0;
      term_item.nest_level    = LVL_TOP;
      term_item.error_code    = term_err;
      term_item.is_last       = 1'b1;

      results.count  = {1'b0, pri_valid} + {1'b0, term_valid};
      results.first  = pri_valid ? pri_item : term_item;
      results.second = term_item;
      if (!step) begin
         results.count = 2'd0;
      end
   end

   // Parse state; a transfer of the byte marked last resets it for a fresh frame
   always_ff @(posedge clock) begin
      if (reset || (step && last_byte)) begin
         phase_ff    <= PH_SRID;
         byte_ff     <= 3'd0;
         assembly_ff <= 64'd0;
         first_ff    <= 64'd0;
         little_ff   <= 1'b1;
         srid_ff     <= 32'd0;
         top_ff      <= GEOM_NONE;
         members_ff  <= 32'd0;
         rings_ff    <= 32'd0;
         points_ff   <= 32'd0;
         finished_ff <= 1'b0;
      end else if (step) begin
         phase_ff    <= phase_in;
         byte_ff     <= byte_in;
         assembly_ff <= assembly_in;
         first_ff    <= first_in;
         little_ff   <= little_in;
         srid_ff     <= srid_in;
         top_ff      <= top_in;
         members_ff  <= members_in;
         rings_ff    <= rings_in;
         points_ff   <= points_in;
         finished_ff <= finished_in;
      end
   end

endmodule

// ===== hw/rtl/wgsp_rsp_queue.sv =====
module wgsp_rsp_queue
   import wgsp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  rsp_pair_type push,
   output logic         room,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_item_type out_item
);

   localparam int unsigned DEPTH = 4;

   rsp_item_type entry_ff [DEPTH];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       pop;
   logic [1:0] wr_next;

   // Room for the two results one byte can cause
   assign room      = (count_ff <= 3'd2);
   assign out_valid = (count_ff != 3'd0);
   assign out_item  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   assign wr_next   = wr_ptr_ff + 2'd1;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + push.count;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + {1'b0, push.count} - {2'b00, pop};
   end

   // Storage, written one or two entries per transfer
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hw/rtl/wkb_geometry_stream_parser.sv =====
// A result is queued on the byte transfer that causes it and offered on rsp from that queue.
// Throughput: one byte per cycle; a byte that causes two results needs two result
// transfers, buffered in a four-entry queue that accepts bytes while it holds two or fewer.
// Reset (synchronous, active high) returns the parse state to the start of a frame,
// empties the result queue and sets the geographic SRID register to 4326.
module wkb_geometry_stream_parser
   import wgsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   wgsp_req_if.sink    req_chan,
   wgsp_rsp_if.source  rsp_chan,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data
);

   logic [31:0]  geo_srid_ff;
   logic         req_transfer;
   logic         queue_room;
   rsp_pair_type pair;
   rsp_item_type head;

   // Geographic SRID register
   always_ff @(posedge clock) begin
      if (reset) begin
         geo_srid_ff <= GEO_SRID_RESET;
      end else if (csr_write_enable) begin
         geo_srid_ff <= csr_write_data;
      end
   end

   assign req_chan.ready = queue_room;
   assign req_transfer   = req_chan.valid && queue_room;

   wgsp_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .step            (req_transfer),
      .data_byte       (req_chan.data_byte),
      .last_byte       (req_chan.last_byte),
      .geographic_srid (geo_srid_ff),
      .results         (pair)
   );

   wgsp_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (pair),
      .room      (queue_room),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_item  (head)
   );

   // Result channel payload
   assign rsp_chan.event_res     = head.event_res;
   assign rsp_chan.srid          = head.srid;
   assign rsp_chan.geom_type     = head.geom_type;
   assign rsp_chan.x_bits        = head.x_bits;
   assign rsp_chan.y_bits        = head.y_bits;
   assign rsp_chan.element_count = head.element_count;
   assign rsp_chan.nest_level    = head.nest_level;
   assign rsp_chan.error_code    = head.error_code;
   assign rsp_chan.is_last       = head.is_last;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import wgsp_pkg::*;

   localparam int LIMIT_CYCLES = 400_000;
   localparam int SEG_BYTES    = 150;
   localparam int MAX_PRINTED  = 150;

   // Byte-level model of the parser plus the queue of events it owes
   class frame_event_board;
      typedef enum logic [4:0] {
         PS_SRID, PS_ORDER, PS_TYPE, PS_TOP_COUNT, PS_MEMBER_ORDER,
         PS_MEMBER_TYPE, PS_MEMBER_COUNT, PS_RING_COUNT, PS_COORD_X, PS_COORD_Y
      } parse_phase_type;

      logic [31:0]     geo_srid;
      parse_phase_type phase;
      logic [2:0]      field_pos;
      logic [63:0]     shift_acc;
      logic [63:0]     held_coord;
      bit              order_le;
      logic [31:0]     frame_srid;
      logic [2:0]      top_geom;
      logic [31:0]     members_left;
      logic [31:0]     rings_left;
      logic [31:0]     points_left;
      bit              frame_done;

      rsp_item_type byte_events[$];
      rsp_item_type pending_events[$];
      int           mismatches;
      int           events_seen;

      function new();
         geo_srid    = GEO_SRID_RESET;
         mismatches  = 0;
         events_seen = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         phase        = PS_SRID;
         field_pos    = '0;
         shift_acc    = '0;
         held_coord   = '0;
         order_le     = 1'b1;
         frame_srid   = '0;
         top_geom     = GEOM_NONE;
         members_left = '0;
         rings_left   = '0;
         points_left  = '0;
         frame_done   = 1'b0;
      endfunction

      function void report(string msg);
         if (mismatches < MAX_PRINTED) $display("mismatch: %s", msg);
         mismatches++;
      endfunction

      // A byte yields at most two events
      function void emit(logic [2:0] ev, logic [63:0] x, logic [63:0] y,
                         logic [31:0] cnt, logic [1:0] lvl, logic [2:0] err);
         rsp_item_type item;
         if (byte_events.size() >= 2) return;
         item.event_res     = ev;
         item.srid          = frame_srid;
         item.geom_type     = top_geom;
         item.x_bits        = x;
         item.y_bits        = y;
         item.element_count = cnt;
         item.nest_level    = lvl;
         item.error_code    = err;
         item.is_last       = 1'b0;
         byte_events.push_back(item);
      endfunction

      function void complete_geometry();
         frame_done = 1'b1;
         emit(EV_DONE, '0, '0, '0, LVL_TOP, ERR_NONE);
      endfunction

      function void abort_frame(logic [2:0] code);
         frame_done = 1'b1;
         emit(EV_ERROR, '0, '0, '0, LVL_TOP, code);
      endfunction

      // Collect one byte of a field; returns 1 with the value once len bytes are in
      function bit take_byte(logic [7:0] b, int len, bit le, output logic [63:0] v);
         if (le) shift_acc = shift_acc | (64'(b) << (8 * field_pos));
         else shift_acc = {shift_acc[55:0], b};
         if (int'(field_pos) + 1 >= len) begin
            v         = shift_acc;
            shift_acc = '0;
            field_pos = '0;
            return 1'b1;
         end
         v = '0;
         field_pos++;
         return 1'b0;
      endfunction

      function void close_member();
         members_left--;
         if (members_left != 0) phase = PS_MEMBER_ORDER;
         else complete_geometry();
      endfunction

      function void close_ring();
         rings_left--;
         if (rings_left != 0) phase = PS_RING_COUNT;
         else if (top_geom == GEOM_POLYGON) complete_geometry();
         else close_member();
      endfunction

      function void close_point();
         if (top_geom == GEOM_POINT) complete_geometry();
         else if (top_geom == GEOM_MPOINT) close_member();
         else begin
            points_left--;
            if (points_left != 0) phase = PS_COORD_X;
            else if (top_geom == GEOM_LINESTRING) complete_geometry();
            else if (top_geom == GEOM_MLINE) close_member();
            else close_ring();
         end
      endfunction

      // Advance the parse by one accepted byte and queue the events it causes
      function void parse_byte(logic [7:0] b, bit last);
         logic [63:0]  v;
         logic [31:0]  c;
         bit           le;
         rsp_item_type item;
         le = order_le;
         byte_events.delete();
         if (!frame_done) begin
            case (phase)
               PS_SRID: begin
                  if (take_byte(b, 4, 1'b1, v)) begin
                     frame_srid = v[31:0];
                     phase      = PS_ORDER;
                  end
               end
               PS_ORDER, PS_MEMBER_ORDER: begin
                  if (b == ORDER_LITTLE || b == ORDER_BIG) begin
                     order_le = (b == ORDER_LITTLE);
                     phase    = (phase == PS_ORDER) ? PS_TYPE : PS_MEMBER_TYPE;
                  end else begin
                     abort_frame(ERR_ORDER);
                  end
               end
               PS_TYPE: begin
                  if (take_byte(b, 4, le, v)) begin
                     if (v[31:0] >= 32'd1 && v[31:0] <= 32'd6) begin
                        top_geom = v[2:0];
                        emit(EV_HEADER, '0, '0, '0, LVL_TOP, ERR_NONE);
                        phase = (v[2:0] == GEOM_POINT) ? PS_COORD_X : PS_TOP_COUNT;
                     end else begin
                        abort_frame(ERR_TYPE);
                     end
                  end
               end
               PS_TOP_COUNT: begin
                  if (take_byte(b, 4, le, v)) begin
                     c = v[31:0];
                     emit(EV_START, '0, '0, c, LVL_TOP, ERR_NONE);
                     if (top_geom == GEOM_LINESTRING) begin
                        points_left = c;
                        if (c != 0) phase = PS_COORD_X;
                        else complete_geometry();
                     end else if (top_geom == GEOM_POLYGON) begin
                        rings_left = c;
                        if (c != 0) phase = PS_RING_COUNT;
                        else complete_geometry();
                     end else begin
                        members_left = c;
                        if (c != 0) phase = PS_MEMBER_ORDER;
                        else complete_geometry();
                     end
                  end
               end
               PS_MEMBER_TYPE: begin
                  if (take_byte(b, 4, le, v)) begin
                     if (v[31:0] != 32'(top_geom) - 32'd3) abort_frame(ERR_MEMBER);
                     else phase = (top_geom == GEOM_MPOINT) ? PS_COORD_X : PS_MEMBER_COUNT;
                  end
               end
               PS_MEMBER_COUNT: begin
                  if (take_byte(b, 4, le, v)) begin
                     c = v[31:0];
                     emit(EV_START, '0, '0, c, LVL_MEMBER, ERR_NONE);
                     if (top_geom == GEOM_MLINE) begin
                        points_left = c;
                        if (c != 0) phase = PS_COORD_X;
                        else close_member();
                     end else begin
                        rings_left = c;
                        if (c != 0) phase = PS_RING_COUNT;
                        else close_member();
                     end
                  end
               end
               PS_RING_COUNT: begin
                  if (take_byte(b, 4, le, v)) begin
                     c           = v[31:0];
                     points_left = c;
                     emit(EV_START, '0, '0, c, LVL_RING, ERR_NONE);
                     if (c != 0) phase = PS_COORD_X;
                     else close_ring();
                  end
               end
               PS_COORD_X: begin
                  if (take_byte(b, 8, le, v)) begin
                     held_coord = v;
                     phase      = PS_COORD_Y;
                  end
               end
               PS_COORD_Y: begin
                  if (take_byte(b, 8, le, v)) begin
                     // geographic frames come out as lon, lat
                     if (frame_srid == geo_srid)
                        emit(EV_POINT, v, held_coord, '0, LVL_TOP, ERR_NONE);
                     else
                        emit(EV_POINT, held_coord, v, '0, LVL_TOP, ERR_NONE);
                     close_point();
                  end
               end
               default: phase = PS_SRID;
            endcase
            if (!frame_done && last) abort_frame(ERR_TRUNC);
         end
         if (byte_events.size() > 0) begin
            item         = byte_events.pop_back();
            item.is_last = 1'b1;
            byte_events.push_back(item);
         end
         foreach (byte_events[i]) pending_events.push_back(byte_events[i]);
         if (last) clear_frame();
      endfunction

      function void compare_field(string name, logic [63:0] got, logic [63:0] want);
         if (got !== want)
            report($sformatf("event %0d %s: got %0h, want %0h", events_seen, name, got, want));
      endfunction

      // Compare one result transfer with the oldest owed event
      function void match_event(rsp_item_type got);
         rsp_item_type want;
         if (pending_events.size() == 0) begin
            report($sformatf("event %0d arrived with none owed (event_res %0d)",
                             events_seen, got.event_res));
            events_seen++;
            return;
         end
         want = pending_events.pop_front();
         compare_field("event_res", 64'(got.event_res), 64'(want.event_res));
         compare_field("srid", 64'(got.srid), 64'(want.srid));
         compare_field("geom_type", 64'(got.geom_type), 64'(want.geom_type));
         compare_field("x_bits", got.x_bits, want.x_bits);
         compare_field("y_bits", got.y_bits, want.y_bits);
         compare_field("element_count", 64'(got.element_count), 64'(want.element_count));
         compare_field("nest_level", 64'(got.nest_level), 64'(want.nest_level));
         compare_field("error_code", 64'(got.error_code), 64'(want.error_code));
         compare_field("is_last", 64'(got.is_last), 64'(want.is_last));
         events_seen++;
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [31:0] csr_write_data;

   wgsp_req_if req_bus();
   wgsp_rsp_if rsp_bus();

   wkb_geometry_stream_parser DUT (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   frame_event_board board;
   rsp_item_type     seen_event;
   logic [7:0]       frame_q[$];
   int               send_idle_pct;
   int               recv_idle_pct;
   int               seg_bytes;
   int               cycle_count;
   int               bad_mark_pct;
   int               bad_type_pct;
   int               bad_member_pct;
   logic [31:0]      geo_settings[6];

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL wkb_geometry_stream_parser");
      $finish;
   end

   // Result side: random back-pressure, changed on the falling edge
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Check every result transfer
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen_event.event_res     = rsp_bus.event_res;
         seen_event.srid          = rsp_bus.srid;
         seen_event.geom_type     = rsp_bus.geom_type;
         seen_event.x_bits        = rsp_bus.x_bits;
         seen_event.y_bits        = rsp_bus.y_bits;
         seen_event.element_count = rsp_bus.element_count;
         seen_event.nest_level    = rsp_bus.nest_level;
         seen_event.error_code    = rsp_bus.error_code;
         seen_event.is_last       = rsp_bus.is_last;
         board.match_event(seen_event);
      end
   end

   // Offer one byte, with random gaps ahead of it, until it is transferred
   task automatic send_byte(input logic [7:0] b, input bit last);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= b;
      req_bus.last_byte <= last;
      do @(posedge clock); while (!req_bus.ready);
      board.parse_byte(b, last);
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_bus.valid <= 1'b0;
   endtask

   // Register write once the block has gone quiet
   task automatic write_geo_srid(input logic [31:0] value);
      while (board.pending_events.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      board.geo_srid = value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_frame();
      int n;
      n = frame_q.size();
      for (int i = 0; i < n; i++) send_byte(frame_q[i], i == n - 1);
      seg_bytes += n;
      frame_q.delete();
   endtask

   // Frame builders
   function automatic void put_u32(logic [31:0] v, bit le);
      for (int i = 0; i < 4; i++) frame_q.push_back(le ? v[8*i +: 8] : v[8*(3-i) +: 8]);
   endfunction

   function automatic void put_f64(logic [63:0] v, bit le);
      for (int i = 0; i < 8; i++) frame_q.push_back(le ? v[8*i +: 8] : v[8*(7-i) +: 8]);
   endfunction

   function automatic void put_order(bit le);
      if ($urandom_range(99) < bad_mark_pct) frame_q.push_back(8'($urandom_range(2, 255)));
      else frame_q.push_back(le ? ORDER_LITTLE : ORDER_BIG);
   endfunction

   function automatic logic [63:0] rand_double();
      case ($urandom_range(7))
         0: return 64'd0;
         1: return '1;
         2: return 64'h3FF0_0000_0000_0000;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic void put_point(bit le);
      put_f64(rand_double(), le);
      put_f64(rand_double(), le);
   endfunction

   // Mostly small counts; a huge one runs into the frame end
   function automatic logic [31:0] pick_count();
      int r;
      r = $urandom_range(19);
      if (r < 3) return 32'd0;
      if (r < 18) return 32'($urandom_range(1, 3));
      if (r == 18) return '1;
      return $urandom;
   endfunction

   function automatic int built_count(logic [31:0] n);
      return (n > 3) ? 3 : int'(n);
   endfunction

   function automatic void put_path(bit le);
      logic [31:0] n;
      n = pick_count();
      put_u32(n, le);
      for (int i = 0; i < built_count(n); i++) put_point(le);
   endfunction

   function automatic void put_rings(bit le);
      logic [31:0] r;
      r = pick_count();
      put_u32(r, le);
      for (int i = 0; i < built_count(r); i++) put_path(le);
   endfunction

   function automatic logic [31:0] member_code(logic [31:0] want);
      logic [31:0] v;
      if ($urandom_range(99) >= bad_member_pct) return want;
      v = 32'($urandom_range(7));
      if (v == want) v = want ^ 32'h0000_0100;
      return v;
   endfunction

   function automatic logic [31:0] bad_top_code();
      case ($urandom_range(4))
         0: return 32'd0;
         1: return 32'd7;
         2: return 32'h0100_0000;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic void put_geometry(logic [2:0] gtype);
      bit          le;
      bit          mle;
      logic [31:0] m;
      le = 1'($urandom_range(1));
      put_order(le);
      if ($urandom_range(99) < bad_type_pct) put_u32(bad_top_code(), le);
      else put_u32(32'(gtype), le);
      case (gtype)
         GEOM_POINT:      put_point(le);
         GEOM_LINESTRING: put_path(le);
         GEOM_POLYGON:    put_rings(le);
         default: begin
            m = pick_count();
            put_u32(m, le);
            for (int i = 0; i < built_count(m); i++) begin
               mle = 1'($urandom_range(1));
               put_order(mle);
               put_u32(member_code(32'(gtype) - 32'd3), mle);
               if (gtype == GEOM_MPOINT) put_point(mle);
               else if (gtype == GEOM_MLINE) put_path(mle);
               else put_rings(mle);
            end
         end
      endcase
   endfunction

   function automatic logic [31:0] pick_srid();
      case ($urandom_range(9))
         0, 1, 2, 3: return board.geo_srid;
         4: return 32'd0;
         5: return '1;
         default: return $urandom;
      endcase
   endfunction

   // Mostly well-formed frames; some cut short, some with trailing bytes, some noise
   task automatic random_frame();
      int kind;
      int cut;
      int extra;
      kind = $urandom_range(99);
      if (kind < 88) begin
         put_u32(pick_srid(), 1'b1);
         put_geometry(3'($urandom_range(1, 6)));
         if (kind >= 70 && kind < 80 && frame_q.size() > 1) begin
            cut = $urandom_range(1, frame_q.size() - 1);
            while (frame_q.size() > cut) void'(frame_q.pop_back());
         end else if (kind >= 80) begin
            extra = $urandom_range(1, 6);
            repeat (extra) frame_q.push_back(8'($urandom));
         end
      end else begin
         extra = $urandom_range(1, 12);
         repeat (extra) frame_q.push_back(8'($urandom));
      end
      send_frame();
   endtask

   initial begin
      board              = new();
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.data_byte  = '0;
      req_bus.last_byte  = 1'b0;
      csr_write_enable   = 1'b0;
      csr_write_data     = '0;
      send_idle_pct      = 16;
      recv_idle_pct      = 85;
      seg_bytes          = 0;
      bad_mark_pct       = 3;
      bad_type_pct       = 4;
      bad_member_pct     = 5;
      geo_settings[0]    = '1;
      geo_settings[1]    = 32'd0;
      geo_settings[2]    = $urandom;
      geo_settings[3]    = $urandom;
      geo_settings[4]    = GEO_SRID_RESET;
      geo_settings[5]    = $urandom;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Frame ended inside the SRID
      frame_q.push_back(8'hFF);
      send_frame();
      // Bad byte-order mark, then a trailing byte that is ignored
      put_u32('1, 1'b1);
      frame_q.push_back(8'h02);
      frame_q.push_back(8'h00);
      send_frame();
      // Unknown type in big-endian order, ending right on the type
      put_u32(32'd0, 1'b1);
      frame_q.push_back(ORDER_BIG);
      put_u32(32'd7, 1'b0);
      send_frame();
      // Empty linestring: header, start with a zero count, done
      put_u32(GEO_SRID_RESET, 1'b1);
      frame_q.push_back(ORDER_LITTLE);
      put_u32(32'(GEOM_LINESTRING), 1'b1);
      put_u32(32'd0, 1'b1);
      send_frame();
      stop_sending();

      // Random segments over register settings and idle modes
      for (int seg = 0; seg < 6; seg++) begin
         if (seg < 2) begin
            send_idle_pct = 16;
            recv_idle_pct = 85;
         end else if (seg < 4) begin
            send_idle_pct = 85;
            recv_idle_pct = 16;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_geo_srid(geo_settings[seg]);
         seg_bytes = 0;
         while (seg_bytes < SEG_BYTES) random_frame();
         stop_sending();
      end

      // Drain
      while (board.pending_events.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (board.pending_events.size() != 0)
         board.report($sformatf("%0d events never arrived", board.pending_events.size()));
      if (board.mismatches == 0) begin
         $display("PASS wkb_geometry_stream_parser");
      end else begin
         $display("FAIL wkb_geometry_stream_parser");
      end
      $finish;
   end

endmodule
